// ===== design/ispm_pkg.sv =====
// ----------------------------------------------------------------------------
// ispm_pkg: shared types and constants for the in-place sorted array merge
// Sizes of the element store, APB register map, the count clamp and the
// structs that travel between the sequencer, the register file and the RAM.
// ----------------------------------------------------------------------------
package ispm_pkg;

  localparam int ARRAY_DEPTH = 32;
  localparam int IDX_W       = $clog2(ARRAY_DEPTH);
  localparam int ADDR_W      = IDX_W + 1;
  localparam int CNT_W       = $clog2(ARRAY_DEPTH + 1);
  localparam int LOAD_W      = $clog2(2 * ARRAY_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int CFG_W       = 6;
  localparam int APB_DW      = 32;
  localparam int PADDR_W     = 3;
  localparam int REG_SEL_BIT = 2;

  localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(ARRAY_DEPTH);

  typedef enum logic {
    REG_FIRST_COUNT  = 1'b0,
    REG_SECOND_COUNT = 1'b1
  } reg_sel_t;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic [CNT_W-1:0] first_n;
    logic [CNT_W-1:0] second_n;
  } count_cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    data_t             wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } ram_req_t;

  // A count of zero means one element; anything above the store depth is cut to it.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (c > CFG_W'(ARRAY_DEPTH)) begin
      r = CNT_W'(ARRAY_DEPTH);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

endpackage

// ===== design/ispm_elem_if.sv =====
// ----------------------------------------------------------------------------
// ispm_elem_if: element input channel
// Valid/ready channel that carries one signed element per request.
// ----------------------------------------------------------------------------
interface ispm_elem_if;
  import ispm_pkg::*;

  logic  valid;
  logic  ready;
  data_t element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);

endinterface

// ===== design/ispm_merge_if.sv =====
// ----------------------------------------------------------------------------
// ispm_merge_if: merged result channel
// Valid/ready channel that carries one merged element and its last flag.
// ----------------------------------------------------------------------------
interface ispm_merge_if;
  import ispm_pkg::*;

  logic  valid;
  logic  ready;
  data_t merged_value;
  logic  last_flag;

  modport source (output valid, output merged_value, output last_flag, input ready);
  modport sink (input valid, input merged_value, input last_flag, output ready);

endinterface

// ===== design/in_place_sorted_array_merge.sv =====
// ----------------------------------------------------------------------------
// in_place_sorted_array_merge: in-place merge of two sorted arrays
// Loads the first then the second sorted array, merges them in place with
// a cross compare and gap passes, and streams the merged result out.
// ----------------------------------------------------------------------------
//  channel   dir   handshake       payload
//  element   in    valid/ready     element_value (s32)
//  merged    out   valid/ready     merged_value (s32), last_flag
//  apb       in    psel/penable    first_count @0x0, second_count @0x4
//
// Loading takes one request per cycle. After the last element, each
// compare-exchange passes a read state and a compare state, plus a high write
// when the pair swaps, since every pair goes through the one dual-read store
// and the one comparator. Each result then passes a store read state, then a present state, plus stalls.
// No element is taken from the final one loaded until the last result goes.
// Synchronous reset sets both counts to 32 and empties the load; the store
// is not cleared. A result held by a low ready stays in place.
// ----------------------------------------------------------------------------
module in_place_sorted_array_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ispm_pkg::PADDR_W-1:0]  paddr,
  input  logic [ispm_pkg::APB_DW-1:0]   pwdata,
  output logic [ispm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  ispm_elem_if.sink                     element,
  ispm_merge_if.source                  merged
);
  import ispm_pkg::*;

  count_cfg_t counts;
  ram_req_t   ram_req;
  data_t      rdata_a, rdata_b;
  data_t      lo_val, hi_hold;
  logic       swap, cmp_capture;

  ispm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .counts  (counts)
  );

  ispm_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  ispm_cmpx u_cmpx (
    .clk     (clk),
    .capture (cmp_capture),
    .a_val   (rdata_a),
    .b_val   (rdata_b),
    .swap    (swap),
    .lo_val  (lo_val),
    .hi_hold (hi_hold)
  );

  ispm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .element     (element),
    .merged      (merged),
    .counts      (counts),
    .ram_req     (ram_req),
    .rdata_a     (rdata_a),
    .swap        (swap),
    .lo_val      (lo_val),
    .hi_hold     (hi_hold),
    .cmp_capture (cmp_capture)
  );

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    element.ready |-> !merged.valid)
    else $error("input ready while a result is offered");

  // Taking the last result hands the block straight back to loading.
  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (merged.valid && merged.ready && merged.last_flag) |=> element.ready)
    else $error("block not ready for loading after the last result");

  // The store is written only by a load request or by the compare unit; the check covers the load side only.
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> ((element.valid && element.ready) || cmp_capture || !element.ready))
    else $error("store written outside load or merge");

endmodule

// ===== design/ispm_regs.sv =====
// ----------------------------------------------------------------------------
// ispm_regs: APB configuration registers
// Holds the two array sizes and hands the clamped counts to the sequencer.
// ----------------------------------------------------------------------------
module ispm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ispm_pkg::PADDR_W-1:0]  paddr,
  input  logic [ispm_pkg::APB_DW-1:0]   pwdata,
  output logic [ispm_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output ispm_pkg::count_cfg_t          counts
);
  import ispm_pkg::*;

  logic [CFG_W-1:0] first_count;
  logic [CFG_W-1:0] second_count;
  logic             wr_en;
  reg_sel_t         sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = reg_sel_t'(paddr[REG_SEL_BIT]);

  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= COUNT_RESET;
      second_count <= COUNT_RESET;
    end else if (wr_en) begin
      unique case (sel)
        REG_FIRST_COUNT:  first_count  <= pwdata[CFG_W-1:0];
        REG_SECOND_COUNT: second_count <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_FIRST_COUNT:  prdata = APB_DW'(first_count);
      REG_SECOND_COUNT: prdata = APB_DW'(second_count);
    endcase
  end

  assign counts.first_n  = clamp_count(first_count);
  assign counts.second_n = clamp_count(second_count);

endmodule

// ===== design/ispm_ram.sv =====
// ----------------------------------------------------------------------------
// ispm_ram: element store
// One write port and two registered read ports. The first array sits in
// the lower half, the second array in the upper half.
// ----------------------------------------------------------------------------
module ispm_ram (
  input  logic               clk,
  input  ispm_pkg::ram_req_t req,
  output ispm_pkg::data_t    rdata_a,
  output ispm_pkg::data_t    rdata_b
);
  import ispm_pkg::*;

  data_t mem [0:2*ARRAY_DEPTH-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_a <= mem[req.raddr_a];
    rdata_b <= mem[req.raddr_b];
  end

endmodule

// ===== design/ispm_cmpx.sv =====
// ----------------------------------------------------------------------------
// ispm_cmpx: compare-exchange unit
// Signed compare of a pair; gives the smaller value and keeps the larger
// one for the second write of a swap.
// ----------------------------------------------------------------------------
module ispm_cmpx (
  input  logic            clk,
  input  logic            capture,
  input  ispm_pkg::data_t a_val,
  input  ispm_pkg::data_t b_val,
  output logic            swap,
  output ispm_pkg::data_t lo_val,
  output ispm_pkg::data_t hi_hold
);
  import ispm_pkg::*;

  assign swap   = a_val > b_val;
  assign lo_val = swap ? b_val : a_val;

  // On a swap the larger value is the old first one; it is written in the following cycle.
  always_ff @(posedge clk) begin
    if (capture) begin
      hi_hold <= a_val;
    end
  end

endmodule

// ===== design/ispm_seq.sv =====
// ----------------------------------------------------------------------------
// ispm_seq: load, merge and emit sequencer
// Loads elements into the store, walks the cross compare and the gap
// passes pair by pair through the shared compare unit, then streams out.
// ----------------------------------------------------------------------------
module ispm_seq (
  input  logic                 clk,
  input  logic                 rst,
  ispm_elem_if.sink            element,
  ispm_merge_if.source         merged,
  input  ispm_pkg::count_cfg_t counts,
  output ispm_pkg::ram_req_t   ram_req,
  input  ispm_pkg::data_t      rdata_a,
  input  logic                 swap,
  input  ispm_pkg::data_t      lo_val,
  input  ispm_pkg::data_t      hi_hold,
  output logic                 cmp_capture
);
  import ispm_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_CMP   = 6'b000100,
    ST_WRHI  = 6'b001000,
    ST_EREAD = 6'b010000,
    ST_EOUT  = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    PH_CROSS = 3'b001,
    PH_GAP1  = 3'b010,
    PH_GAP2  = 3'b100
  } phase_t;

  function automatic logic [IDX_W-1:0] half_up(input logic [CNT_W-1:0] x);
    logic [SUM_W-1:0] s;
    s = SUM_W'(x) + SUM_W'(1);
    return IDX_W'(s >> 1);
  endfunction

  state_t            state;
  phase_t            phase, phase_next;
  logic [LOAD_W-1:0] load_count;
  logic [IDX_W-1:0]  k, k_next;
  logic [IDX_W-1:0]  gap, gap_next;
  logic              e_bank;
  logic [IDX_W-1:0]  e_idx;

  logic [CNT_W-1:0]  n, m, lo_cnt, cur_cnt, cross_idx;
  logic [LOAD_W-1:0] total, load_inc, load_off;
  logic [ADDR_W-1:0] load_addr, addr_a, addr_b, emit_addr;
  logic [SUM_W-1:0]  k_inc, far_inc, e_inc;
  logic [IDX_W-1:0]  k_far;
  logic              accept_in, store_en, load_done, pass_more, pairs_done;
  logic              first_done, out_take, is_last;

  assign n      = counts.first_n;
  assign m      = counts.second_n;
  assign lo_cnt = (m < n) ? m : n;
  assign total  = LOAD_W'(n) + LOAD_W'(m);

  assign element.ready = (state == ST_LOAD);
  assign accept_in     = element.valid && element.ready;
  assign load_inc      = load_count + LOAD_W'(1);
  // A load that already reached the total (counts shrank) merges on the next request.
  assign store_en      = accept_in && (load_count < total);
  assign load_done     = load_inc >= total;
  assign load_off      = load_count - LOAD_W'(n);
  assign load_addr     = (load_count < LOAD_W'(n)) ? {1'b0, load_count[IDX_W-1:0]}
                                                   : {1'b1, load_off[IDX_W-1:0]};

  // Pair addresses for the current compare-exchange.
  assign cross_idx = n - CNT_W'(1) - CNT_W'(k);
  assign k_inc     = SUM_W'(k) + SUM_W'(1);
  assign k_far     = IDX_W'(SUM_W'(k) + SUM_W'(gap));
  assign far_inc   = k_inc + SUM_W'(gap);
  assign cur_cnt   = (phase == PH_GAP1) ? n : m;
  assign pass_more = far_inc < SUM_W'(cur_cnt);

  always_comb begin
    unique case (phase)
      PH_CROSS: begin
        addr_a = {1'b0, cross_idx[IDX_W-1:0]};
        addr_b = {1'b1, k};
      end
      PH_GAP1: begin
        addr_a = {1'b0, k};
        addr_b = {1'b0, k_far};
      end
      PH_GAP2: begin
        addr_a = {1'b1, k};
        addr_b = {1'b1, k_far};
      end
      default: begin
        addr_a = '0;
        addr_b = '0;
      end
    endcase
  end

  // Step to the next pair: next index, next gap, next array, or done.
  always_comb begin
    phase_next = phase;
    k_next     = k;
    gap_next   = gap;
    pairs_done = 1'b0;
    unique case (phase)
      PH_CROSS: begin
        if (k_inc < SUM_W'(lo_cnt)) begin
          k_next = k_inc[IDX_W-1:0];
        end else if (n > CNT_W'(1)) begin
          phase_next = PH_GAP1;
          k_next     = '0;
          gap_next   = half_up(n);
        end else if (m > CNT_W'(1)) begin
          phase_next = PH_GAP2;
          k_next     = '0;
          gap_next   = half_up(m);
        end else begin
          pairs_done = 1'b1;
        end
      end
      PH_GAP1: begin
        if (pass_more) begin
          k_next = k_inc[IDX_W-1:0];
        end else if (gap != IDX_W'(1)) begin
          k_next   = '0;
          gap_next = half_up(CNT_W'(gap));
        end else if (m > CNT_W'(1)) begin
          phase_next = PH_GAP2;
          k_next     = '0;
          gap_next   = half_up(m);
        end else begin
          pairs_done = 1'b1;
        end
      end
      PH_GAP2: begin
        if (pass_more) begin
          k_next = k_inc[IDX_W-1:0];
        end else if (gap != IDX_W'(1)) begin
          k_next   = '0;
          gap_next = half_up(CNT_W'(gap));
        end else begin
          pairs_done = 1'b1;
        end
      end
      default: begin
        pairs_done = 1'b1;
      end
    endcase
  end

  // Result stream.
  assign emit_addr  = {e_bank, e_idx};
  assign e_inc      = SUM_W'(e_idx) + SUM_W'(1);
  assign first_done = !e_bank && (e_inc == SUM_W'(n));
  assign is_last    = e_bank && (e_inc == SUM_W'(m));
  assign out_take   = merged.valid && merged.ready;

  assign merged.valid        = (state == ST_EOUT);
  assign merged.merged_value = rdata_a;
  assign merged.last_flag    = is_last;

  assign cmp_capture = (state == ST_CMP);

  always_comb begin
    ram_req.we      = store_en || ((state == ST_CMP) && swap) || (state == ST_WRHI);
    ram_req.waddr   = load_addr;
    ram_req.wdata   = element.element_value;
    if (state == ST_CMP) begin
      ram_req.waddr = addr_a;
      ram_req.wdata = lo_val;
    end else if (state == ST_WRHI) begin
      ram_req.waddr = addr_b;
      ram_req.wdata = hi_hold;
    end
    ram_req.raddr_a = ((state == ST_EREAD) || (state == ST_EOUT)) ? emit_addr : addr_a;
    ram_req.raddr_b = addr_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      phase      <= PH_CROSS;
      load_count <= '0;
      k          <= '0;
      gap        <= '0;
      e_bank     <= 1'b0;
      e_idx      <= '0;
    end else begin
      unique case (state) inside
        ST_LOAD: begin
          if (accept_in && load_done) begin
            load_count <= '0;
            phase      <= PH_CROSS;
            k          <= '0;
            state      <= ST_READ;
          end else if (store_en) begin
            load_count <= load_inc;
          end
        end
        ST_READ: begin
          state <= ST_CMP;
        end
        ST_CMP, ST_WRHI: begin
          if ((state == ST_CMP) && swap) begin
            state <= ST_WRHI;
          end else if (pairs_done) begin
            e_bank <= 1'b0;
            e_idx  <= '0;
            state  <= ST_EREAD;
          end else begin
            phase <= phase_next;
            k     <= k_next;
            gap   <= gap_next;
            state <= ST_READ;
          end
        end
        ST_EREAD: begin
          state <= ST_EOUT;
        end
        ST_EOUT: begin
          if (out_take) begin
            if (is_last) begin
              state <= ST_LOAD;
            end else begin
              if (first_done) begin
                e_bank <= 1'b1;
                e_idx  <= '0;
              end else begin
                e_idx <= e_inc[IDX_W-1:0];
              end
              state <= ST_EREAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
